// File: hw/rtl/mls_pkg.sv
// shared types, codes and helpers of the multicore lottery scheduler
`timescale 1ns / 1ps

package mls_pkg;

  // operation codes carried in the input tuser
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;
  localparam logic [1:0] OP_SPARE = 2'd3;  // spare code, ignored

  // record kinds carried in the output tuser
  localparam logic KIND_DONE = 1'b0;
  localparam logic KIND_SLOT = 1'b1;

  // completion counter ceiling
  localparam logic [4:0] DONE_MAX = 5'd31;

  // register indexes on the config port
  localparam logic REG_PROC_COUNT  = 1'b0;
  localparam logic REG_ACTIVE_CPUS = 1'b1;

  // one process table word
  typedef struct packed {
    logic [3:0] weight;
    logic [9:0] burst;
    logic [9:0] arrival;
    logic [7:0] pid;
  } proc_t;

  // clamp a signed metric to 0..2047
  function automatic logic [10:0] sat11(input logic signed [31:0] v);
    logic [10:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > 32'sd2047) begin
      r = 11'd2047;
    end else begin
      r = v[10:0];
    end
    return r;
  endfunction

endpackage

// File: hw/rtl/mls_ram.sv
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module mls_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/multicore_lottery_scheduler.sv
// top level of the multicore lottery scheduler
`timescale 1ns / 1ps

// Takes one item at a time. A load or start transfer is taken in the idle
// state and does not start the sequencer. A tick runs a sequencer over the
// process table memory, one read port shared by every pass: a check step, a
// read and a check per active CPU to find finished processes, a read and an
// output per completion record, and for each idle CPU a select step, a ticket
// sum scan, a bit-serial modulo of the 16-bit draw and a winner scan, then a
// read and an output per timeline slot. Results leave through an output
// register, so a slow consumer only stalls the sequencer when a second record
// is ready. The table has no reset: entries must be loaded before a run uses
// them.

module multicore_lottery_scheduler #(
  parameter int NUM_PROCS  = 16,
  parameter int MAX_CPUS   = 4,
  parameter int TIME_LIMIT = 1024
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // input stream
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // entry_index[3:0] proc_id[11:4] arrival[21:12] burst[31:22]
  // weight_level[35:32] rand_cpu0[51:36] rand_cpu1[67:52]
  // rand_cpu2[83:68] rand_cpu3[99:84]
  input  logic [103:0] s_axis_tdata,
  // operation[1:0]
  input  logic [1:0]   s_axis_tuser,
  // result stream
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // cpu_number[1:0] busy_res[2] out_pid[10:3] finish_time[21:11]
  // turnaround[32:22] wait_time[43:33] all_done[44]
  output logic [47:0]  m_axis_tdata,
  // record_kind[0]
  output logic [0:0]   m_axis_tuser,
  output logic         m_axis_tlast,
  // config port
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int PW    = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int CNT_W = $clog2(NUM_PROCS + 1);
  localparam int TW    = $clog2(NUM_PROCS * 16 + 1);
  localparam int NW    = $clog2(TIME_LIMIT + 1);
  localparam int XW    = (NW > 10) ? NW : 10;
  localparam int CIW   = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;

  // sequencer states
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_CHECK    = 4'd1;
  localparam logic [3:0] ST_REL_RD   = 4'd2;
  localparam logic [3:0] ST_REL_CHK  = 4'd3;
  localparam logic [3:0] ST_CMP_RD   = 4'd4;
  localparam logic [3:0] ST_CMP_OUT  = 4'd5;
  localparam logic [3:0] ST_LOT_SEL  = 4'd6;
  localparam logic [3:0] ST_LOT_SUM  = 4'd7;
  localparam logic [3:0] ST_LOT_DIV  = 4'd8;
  localparam logic [3:0] ST_LOT_PICK = 4'd9;
  localparam logic [3:0] ST_TL_RD    = 4'd10;
  localparam logic [3:0] ST_TL_OUT   = 4'd11;

  // config registers
  logic [4:0] proc_count_q;
  logic [2:0] active_cpus_q;

  // control state
  logic [3:0]          state_q, state_d;
  logic [CIW-1:0]      c_q, c_d;
  logic [MAX_CPUS-1:0] rel_q, rel_d;
  logic [4:0]          done_q, done_d;
  logic                done_flag_q, done_flag_d;
  logic [NW-1:0]       now_q, now_d;
  logic [MAX_CPUS-1:0] busy_q, busy_d;
  logic [PW-1:0]       entry_q [MAX_CPUS];
  logic [PW-1:0]       entry_d [MAX_CPUS];
  logic [NUM_PROCS-1:0] running_q, running_d;
  logic [CNT_W-1:0]    issue_q, issue_d;
  logic                pend_q, pend_d;
  logic [PW-1:0]       pend_idx_q, pend_idx_d;
  logic [TW-1:0]       total_q, total_d;
  logic [TW-1:0]       sum_q, sum_d;
  logic [TW-1:0]       win_q, win_d;
  logic [15:0]         dvd_q, dvd_d;
  logic [3:0]          cnt_q, cnt_d;

  // captured random draws
  logic [15:0] rand_q [4];

  // output register
  logic        ovalid_q, ovalid_d;
  logic        okind_q, okind_d;
  logic [1:0]  ocpu_q, ocpu_d;
  logic        obusy_q, obusy_d;
  logic [7:0]  opid_q, opid_d;
  logic [10:0] ofin_q, ofin_d;
  logic [10:0] ota_q, ota_d;
  logic [10:0] owait_q, owait_d;
  logic        odone_q, odone_d;
  logic        olast_q, olast_d;

  // memory ports
  logic                 tab_we, rem_we, mem_re;
  logic [PW-1:0]        mem_waddr, mem_raddr;
  logic [9:0]           rem_wdata, rem_rdata;
  mls_pkg::proc_t       tab_wdata, tab_rdata;

  // derived values
  logic [CNT_W-1:0] np;
  logic [CIW-1:0]   nc_m1;
  logic             c_last;
  logic             in_xfer, cfg_wr;
  logic             slot_free;
  logic             issue_go, elig;
  logic [TW-1:0]    tickets;
  logic [TW-1:0]    sum_n;
  logic [TW:0]      div_tmp;
  logic [15:0]      rand_sel;
  logic [5:0]       done_sum;
  logic signed [31:0] ta_s, wait_s;

  mls_ram #(.WIDTH(32), .DEPTH(NUM_PROCS)) u_tab_ram (
    .clk_i   (clk_i),
    .we_i    (tab_we),
    .waddr_i (mem_waddr),
    .wdata_i (tab_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (tab_rdata)
  );

  mls_ram #(.WIDTH(10), .DEPTH(NUM_PROCS)) u_rem_ram (
    .clk_i   (clk_i),
    .we_i    (rem_we),
    .waddr_i (mem_waddr),
    .wdata_i (rem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rem_rdata)
  );

  // handshakes
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign cfg_wr        = psel & penable & pwrite;
  assign pready        = 1'b1;
  assign slot_free     = ~ovalid_q | m_axis_tready;

  always_comb begin
    if (paddr[2] == mls_pkg::REG_ACTIVE_CPUS) begin
      prdata = {29'd0, active_cpus_q};
    end else begin
      prdata = {27'd0, proc_count_q};
    end
  end

  // register values clamped to what the hardware has
  always_comb begin
    if (32'(proc_count_q) > NUM_PROCS) begin
      np = CNT_W'(NUM_PROCS);
    end else begin
      np = CNT_W'(proc_count_q);
    end
    if (active_cpus_q == 3'd0) begin
      nc_m1 = '0;
    end else if (32'(active_cpus_q) > MAX_CPUS) begin
      nc_m1 = CIW'(MAX_CPUS - 1);
    end else begin
      nc_m1 = CIW'(active_cpus_q - 3'd1);
    end
  end

  assign c_last = (c_q == nc_m1);

  always_comb begin
    case (2'(c_q))
      2'd0:    rand_sel = rand_q[0];
      2'd1:    rand_sel = rand_q[1];
      2'd2:    rand_sel = rand_q[2];
      default: rand_sel = rand_q[3];
    endcase
  end

  // scan datapath: one table entry returns per cycle
  assign issue_go = (issue_q < np);
  assign elig     = pend_q & (XW'(tab_rdata.arrival) <= XW'(now_q)) &
                    (rem_rdata != 10'd0) & ~running_q[pend_idx_q];
  assign tickets  = TW'(tab_rdata.weight) + TW'(1);
  assign sum_n    = sum_q + tickets;
  assign div_tmp  = {win_q, dvd_q[15]};
  assign done_sum = {1'b0, done_q} + 6'($countones(rel_d));

  // completion metrics, clamped
  assign ta_s   = $signed(32'(now_q)) - $signed(32'(tab_rdata.arrival));
  assign wait_s = ta_s - $signed(32'(tab_rdata.burst));

  always_comb begin
    state_d     = state_q;
    c_d         = c_q;
    rel_d       = rel_q;
    done_d      = done_q;
    done_flag_d = done_flag_q;
    now_d       = now_q;
    busy_d      = busy_q;
    entry_d     = entry_q;
    running_d   = running_q;
    issue_d     = issue_q;
    pend_d      = 1'b0;
    pend_idx_d  = pend_idx_q;
    total_d     = total_q;
    sum_d       = sum_q;
    win_d       = win_q;
    dvd_d       = dvd_q;
    cnt_d       = cnt_q;

    ovalid_d = ovalid_q & ~m_axis_tready;
    okind_d  = okind_q;
    ocpu_d   = ocpu_q;
    obusy_d  = obusy_q;
    opid_d   = opid_q;
    ofin_d   = ofin_q;
    ota_d    = ota_q;
    owait_d  = owait_q;
    odone_d  = odone_q;
    olast_d  = olast_q;

    tab_we    = 1'b0;
    rem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = entry_q[c_q];
    mem_raddr = entry_q[c_q];
    tab_wdata = '{weight: s_axis_tdata[35:32], burst: s_axis_tdata[31:22],
                  arrival: s_axis_tdata[21:12], pid: s_axis_tdata[11:4]};
    rem_wdata = s_axis_tdata[31:22];

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          case (s_axis_tuser)
            mls_pkg::OP_LOAD: begin
              if (32'(s_axis_tdata[3:0]) < NUM_PROCS) begin
                tab_we    = 1'b1;
                rem_we    = 1'b1;
                mem_waddr = PW'(s_axis_tdata[3:0]);
              end
            end
            mls_pkg::OP_TICK: begin
              state_d = ST_CHECK;
            end
            mls_pkg::OP_START: begin
              now_d     = '0;
              done_d    = '0;
              busy_d    = '0;
              running_d = '0;
              for (int k = 0; k < MAX_CPUS; k++) begin
                entry_d[k] = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // a finished run or the time limit turns the tick into a no-op
      ST_CHECK: begin
        c_d   = '0;
        rel_d = '0;
        if ((32'(done_q) >= 32'(np)) || (32'(now_q) >= TIME_LIMIT)) begin
          state_d = ST_IDLE;
        end else begin
          state_d = ST_REL_RD;
        end
      end

      // find every cpu whose process has run out before any record leaves
      ST_REL_RD: begin
        mem_re  = 1'b1;
        state_d = ST_REL_CHK;
      end

      ST_REL_CHK: begin
        rel_d[c_q] = busy_q[c_q] & (rem_rdata == 10'd0);
        if (c_last) begin
          done_d      = (done_sum > 6'(mls_pkg::DONE_MAX)) ?
                        mls_pkg::DONE_MAX : done_sum[4:0];
          done_flag_d = (32'(done_d) >= 32'(np));
          c_d         = '0;
          state_d     = ST_CMP_RD;
        end else begin
          c_d     = c_q + CIW'(1);
          state_d = ST_REL_RD;
        end
      end

      ST_CMP_RD: begin
        if (rel_q[c_q]) begin
          mem_re  = 1'b1;
          state_d = ST_CMP_OUT;
        end else if (c_last) begin
          c_d     = '0;
          state_d = ST_LOT_SEL;
        end else begin
          c_d = c_q + CIW'(1);
        end
      end

      ST_CMP_OUT: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          okind_d  = mls_pkg::KIND_DONE;
          ocpu_d   = 2'(c_q);
          obusy_d  = 1'b0;
          opid_d   = tab_rdata.pid;
          ofin_d   = mls_pkg::sat11($signed(32'(now_q)));
          ota_d    = mls_pkg::sat11(ta_s);
          owait_d  = mls_pkg::sat11(wait_s);
          odone_d  = done_flag_q;
          olast_d  = 1'b0;
          busy_d[c_q]               = 1'b0;
          running_d[entry_q[c_q]]   = 1'b0;
          if (c_last) begin
            c_d     = '0;
            state_d = ST_LOT_SEL;
          end else begin
            c_d     = c_q + CIW'(1);
            state_d = ST_CMP_RD;
          end
        end
      end

      // idle cpus draw in cpu order
      ST_LOT_SEL: begin
        issue_d = '0;
        total_d = '0;
        sum_d   = '0;
        if (!busy_q[c_q]) begin
          state_d = ST_LOT_SUM;
        end else if (c_last) begin
          c_d     = '0;
          state_d = ST_TL_RD;
        end else begin
          c_d = c_q + CIW'(1);
        end
      end

      ST_LOT_SUM: begin
        mem_re     = issue_go;
        mem_raddr  = issue_q[PW-1:0];
        pend_d     = issue_go;
        pend_idx_d = issue_q[PW-1:0];
        if (issue_go) begin
          issue_d = issue_q + CNT_W'(1);
        end
        if (elig) begin
          total_d = total_q + tickets;
        end
        if (!issue_go && !pend_q) begin
          win_d = '0;
          dvd_d = rand_sel;
          cnt_d = '0;
          if (total_q == '0) begin
            if (c_last) begin
              c_d     = '0;
              state_d = ST_TL_RD;
            end else begin
              c_d     = c_q + CIW'(1);
              state_d = ST_LOT_SEL;
            end
          end else begin
            state_d = ST_LOT_DIV;
          end
        end
      end

      // restoring remainder, one draw bit per cycle
      ST_LOT_DIV: begin
        dvd_d = {dvd_q[14:0], 1'b0};
        cnt_d = cnt_q + 4'd1;
        if (div_tmp >= {1'b0, total_q}) begin
          win_d = TW'(div_tmp - {1'b0, total_q});
        end else begin
          win_d = div_tmp[TW-1:0];
        end
        if (cnt_q == 4'd15) begin
          issue_d = '0;
          sum_d   = '0;
          state_d = ST_LOT_PICK;
        end
      end

      ST_LOT_PICK: begin
        mem_re     = issue_go;
        mem_raddr  = issue_q[PW-1:0];
        pend_d     = issue_go;
        pend_idx_d = issue_q[PW-1:0];
        if (issue_go) begin
          issue_d = issue_q + CNT_W'(1);
        end
        if (elig) begin
          sum_d = sum_n;
        end
        if ((elig && (sum_n > win_q)) || (!issue_go && !pend_q)) begin
          if (elig && (sum_n > win_q)) begin
            busy_d[c_q]            = 1'b1;
            entry_d[c_q]           = pend_idx_q;
            running_d[pend_idx_q]  = 1'b1;
          end
          if (c_last) begin
            c_d     = '0;
            state_d = ST_TL_RD;
          end else begin
            c_d     = c_q + CIW'(1);
            state_d = ST_LOT_SEL;
          end
        end
      end

      // one timeline slot per active cpu, running process loses one tick
      ST_TL_RD: begin
        mem_re  = 1'b1;
        state_d = ST_TL_OUT;
      end

      ST_TL_OUT: begin
        if (slot_free) begin
          ovalid_d = 1'b1;
          okind_d  = mls_pkg::KIND_SLOT;
          ocpu_d   = 2'(c_q);
          obusy_d  = busy_q[c_q];
          opid_d   = busy_q[c_q] ? tab_rdata.pid : 8'd0;
          ofin_d   = '0;
          ota_d    = '0;
          owait_d  = '0;
          odone_d  = done_flag_q;
          olast_d  = c_last;
          if (busy_q[c_q] && (rem_rdata != 10'd0)) begin
            rem_we    = 1'b1;
            rem_wdata = rem_rdata - 10'd1;
          end
          if (c_last) begin
            now_d   = now_q + NW'(1);
            state_d = ST_IDLE;
          end else begin
            c_d     = c_q + CIW'(1);
            state_d = ST_TL_RD;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      proc_count_q  <= 5'd1;
      active_cpus_q <= 3'd1;
      state_q       <= ST_IDLE;
      c_q           <= '0;
      rel_q         <= '0;
      done_q        <= '0;
      done_flag_q   <= 1'b0;
      now_q         <= '0;
      busy_q        <= '0;
      running_q     <= '0;
      issue_q       <= '0;
      pend_q        <= 1'b0;
      cnt_q         <= '0;
      ovalid_q      <= 1'b0;
      for (int k = 0; k < MAX_CPUS; k++) begin
        entry_q[k] <= '0;
      end
    end else begin
      if (cfg_wr) begin
        if (paddr[2] == mls_pkg::REG_PROC_COUNT) begin
          proc_count_q <= pwdata[4:0];
        end else begin
          active_cpus_q <= pwdata[2:0];
        end
      end
      state_q     <= state_d;
      c_q         <= c_d;
      rel_q       <= rel_d;
      done_q      <= done_d;
      done_flag_q <= done_flag_d;
      now_q       <= now_d;
      busy_q      <= busy_d;
      running_q   <= running_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
      ovalid_q    <= ovalid_d;
      entry_q     <= entry_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer && (s_axis_tuser == mls_pkg::OP_TICK)) begin
      rand_q[0] <= s_axis_tdata[51:36];
      rand_q[1] <= s_axis_tdata[67:52];
      rand_q[2] <= s_axis_tdata[83:68];
      rand_q[3] <= s_axis_tdata[99:84];
    end
    pend_idx_q <= pend_idx_d;
    total_q    <= total_d;
    sum_q      <= sum_d;
    win_q      <= win_d;
    dvd_q      <= dvd_d;
    okind_q    <= okind_d;
    ocpu_q     <= ocpu_d;
    obusy_q    <= obusy_d;
    opid_q     <= opid_d;
    ofin_q     <= ofin_d;
    ota_q      <= ota_d;
    owait_q    <= owait_d;
    odone_q    <= odone_d;
    olast_q    <= olast_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {3'd0, odone_q, owait_q, ota_q, ofin_q, opid_q, obusy_q, ocpu_q};
  assign m_axis_tuser  = okind_q;
  assign m_axis_tlast  = olast_q;

  // every busy cpu owns exactly one running entry
  a_run_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(running_q) == $countones(busy_q))
    else $error("running flags and busy cpus disagree");

  for (genvar k = 0; k < MAX_CPUS; k++) begin : g_own
    a_busy_owns : assert property (@(posedge clk_i) disable iff (!rst_ni)
      busy_q[k] |-> running_q[entry_q[k]])
      else $error("busy cpu entry not marked running");
  end

  // the draw always lands inside the ticket range
  a_win_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOT_PICK) |-> (win_q < total_q))
    else $error("lottery draw outside ticket total");

endmodule
